// File: rtl/core/gfrd_pkg.sv
// Shared types and constants for the gamepad frame receiver / debounce core.
// No dependencies; every other file in rtl/core refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package gfrd_pkg;

    localparam int FRAME_DEPTH = 8;
    localparam int IDX_W       = $clog2(FRAME_DEPTH);
    // bytes of a frame that carry payload: two button bytes, four stick bytes
    localparam int FRAME_USED  = 6;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_DEPTH - 1);

    localparam logic [7:0] START_BYTE      = 8'h0D;
    localparam logic [7:0] END_BYTE        = 8'h0A;
    localparam logic [7:0] DISCONNECT_BYTE = 8'hAB;

    localparam logic [15:0] DEBOUNCE_RESET = 16'd30;
    localparam logic [7:0]  STICK_X_RESET  = 8'd128;
    localparam logic [7:0]  STICK_Y_RESET  = 8'd127;

    localparam logic FUNC_BYTE  = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    // framer -> debounce / output
    typedef struct packed {
        logic        done;
        logic        link_up;
        logic [15:0] raw;
        logic [7:0]  left_x;
        logic [7:0]  left_y;
        logic [7:0]  right_x;
        logic [7:0]  right_y;
    } frame_t;

    // debounce -> output
    typedef struct packed {
        logic [15:0] stable;
        logic [15:0] raw;
        logic [15:0] pressed;
        logic [15:0] released;
        logic        pressed_hit;
        logic        released_hit;
    } btn_t;

endpackage

`default_nettype wire

// File: rtl/core/gfrd_framer.sv
// Byte framer: start/end/disconnect handling, frame store and stick latch.
// Depends on gfrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gfrd_framer (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire logic [7:0]      rx_byte,
    output gfrd_pkg::frame_t     frame
);

    logic [7:0]                  store_reg [gfrd_pkg::FRAME_DEPTH];
    logic [gfrd_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic                        in_frame_reg, in_frame_next;
    logic                        ignore_reg, ignore_next;
    logic [7:0]                  lx_reg, ly_reg, rx_reg, ry_reg;
    logic                        wr_en;
    logic [7:0]                  wr_data;
    logic                        done;
    logic [7:0]                  view [gfrd_pkg::FRAME_USED];

    always_comb
    begin
        idx_next      = idx_reg;
        in_frame_next = in_frame_reg;
        ignore_next   = ignore_reg;
        wr_en         = 1'b0;
        wr_data       = rx_byte;
        done          = 1'b0;
        if (step)
        begin
            priority if (rx_byte == gfrd_pkg::DISCONNECT_BYTE)
            begin
                in_frame_next = 1'b0;
                idx_next      = '0;
                ignore_next   = 1'b1;
            end
            else if (ignore_reg)
            begin
                if (rx_byte == gfrd_pkg::START_BYTE)
                begin
                    ignore_next   = 1'b0;
                    in_frame_next = 1'b1;
                    idx_next      = '0;
                end
            end
            else if (in_frame_reg)
            begin
                wr_en = 1'b1;
                if (rx_byte != gfrd_pkg::END_BYTE)
                begin
                    idx_next = (idx_reg == gfrd_pkg::LAST_IDX) ? gfrd_pkg::LAST_IDX
                             : idx_reg + gfrd_pkg::IDX_W'(1);
                end
                else
                begin
                    wr_data       = gfrd_pkg::END_BYTE;
                    in_frame_next = 1'b0;
                    idx_next      = '0;
                    done          = 1'b1;
                end
            end
            else
            begin
                if (rx_byte == gfrd_pkg::START_BYTE)
                begin
                    in_frame_next = 1'b1;
                    idx_next      = '0;
                end
            end
        end
    end

    // frame contents including the end byte written in this same step
    always_comb
    begin
        for (int i = 0; i < gfrd_pkg::FRAME_USED; i++)
        begin
            view[i] = (idx_reg == gfrd_pkg::IDX_W'(i)) ? gfrd_pkg::END_BYTE : store_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < gfrd_pkg::FRAME_DEPTH; i++)
            begin
                store_reg[i] <= '0;
            end
            idx_reg      <= '0;
            in_frame_reg <= 1'b0;
            ignore_reg   <= 1'b0;
            lx_reg       <= gfrd_pkg::STICK_X_RESET;
            ly_reg       <= gfrd_pkg::STICK_Y_RESET;
            rx_reg       <= gfrd_pkg::STICK_X_RESET;
            ry_reg       <= gfrd_pkg::STICK_Y_RESET;
        end
        else
        begin
            if (wr_en)
            begin
                store_reg[idx_reg] <= wr_data;
            end
            idx_reg      <= idx_next;
            in_frame_reg <= in_frame_next;
            ignore_reg   <= ignore_next;
            if (done)
            begin
                ly_reg <= view[2];
                lx_reg <= view[3];
                ry_reg <= view[4];
                rx_reg <= view[5];
            end
        end
    end

    assign frame.done    = done;
    assign frame.link_up = ~ignore_next;
    assign frame.raw     = {view[0], view[1]};
    assign frame.left_x  = done ? view[3] : lx_reg;
    assign frame.left_y  = done ? view[2] : ly_reg;
    assign frame.right_x = done ? view[5] : rx_reg;
    assign frame.right_y = done ? view[4] : ry_reg;

endmodule

`default_nettype wire

// File: rtl/core/gfrd_debounce.sv
// Button debounce with sticky pressed/released event masks and masked clear.
// Depends on gfrd_pkg; fed by gfrd_framer.
`timescale 1ns / 1ps
`default_nettype none

module gfrd_debounce (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic             func,
    input  wire logic [31:0]      now_ms,
    input  wire logic [15:0]      clear_pressed_mask,
    input  wire logic [15:0]      clear_released_mask,
    input  wire logic [15:0]      debounce_ms,
    input  wire gfrd_pkg::frame_t frame,
    output gfrd_pkg::btn_t        btn
);

    logic [15:0] raw_reg, raw_next;
    logic [15:0] stable_reg, stable_next;
    logic [15:0] pressed_reg, pressed_next;
    logic [15:0] released_reg, released_next;
    logic [31:0] start_reg, start_next;
    logic [31:0] elapsed;
    logic [15:0] hit_p, hit_r;

    assign elapsed = now_ms - start_reg;
    assign hit_p   = pressed_reg & clear_pressed_mask;
    assign hit_r   = released_reg & clear_released_mask;

    always_comb
    begin
        raw_next      = raw_reg;
        stable_next   = stable_reg;
        pressed_next  = pressed_reg;
        released_next = released_reg;
        start_next    = start_reg;
        if (step)
        begin
            unique case (func)
                gfrd_pkg::FUNC_BYTE:
                begin
                    if (frame.done)
                    begin
                        if (frame.raw != raw_reg)
                        begin
                            raw_next   = frame.raw;
                            start_next = now_ms;
                        end
                        else if (!elapsed[31] && elapsed >= {16'd0, debounce_ms}
                                 && stable_reg != frame.raw)
                        begin
                            stable_next   = frame.raw;
                            pressed_next  = pressed_reg | (frame.raw & ~stable_reg);
                            released_next = released_reg | (stable_reg & ~frame.raw);
                        end
                    end
                end
                gfrd_pkg::FUNC_CLEAR:
                begin
                    pressed_next  = pressed_reg & ~hit_p;
                    released_next = released_reg & ~hit_r;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg      <= '0;
            stable_reg   <= '0;
            pressed_reg  <= '0;
            released_reg <= '0;
            start_reg    <= '0;
        end
        else
        begin
            raw_reg      <= raw_next;
            stable_reg   <= stable_next;
            pressed_reg  <= pressed_next;
            released_reg <= released_next;
            start_reg    <= start_next;
        end
    end

    assign btn.stable       = stable_next;
    assign btn.raw          = raw_next;
    assign btn.pressed      = pressed_next;
    assign btn.released     = released_next;
    assign btn.pressed_hit  = (func == gfrd_pkg::FUNC_CLEAR) && (hit_p != '0);
    assign btn.released_hit = (func == gfrd_pkg::FUNC_CLEAR) && (hit_r != '0);

endmodule

`default_nettype wire

// File: rtl/core/gamepad_frame_receiver_debounce_core.sv
// Top level of the gamepad frame receiver with button debounce.
// Depends on gfrd_pkg, gfrd_framer and gfrd_debounce.
//
// Usage:
//   s_axis: one transfer per received byte (tuser = 0) or per event clear
//   request (tuser = 1). Every input transfer yields exactly one m_axis
//   transfer carrying the button, event, stick and link state after it.
//   cfg: a write sets debounce_ms; cfg_ready is always high. Write it only
//   while no item is in flight.
// Path: the input register loads at the input transfer; the result register
//   loads from it when the output can advance (result register empty or
//   m_axis_tready high).
// Throughput: one item per cycle unless m_axis stalls; all per-item work is a
//   single pass of logic between the input register and the result register.
// Stall: when a result waits with m_axis_tready low the result register holds;
//   one more item may sit in the input register, after which s_axis_tready drops.
// Reset: rst_n clears framing state, the frame store, button and event
//   state, sets sticks to 128/127/128/127 and debounce_ms to 30.
`timescale 1ns / 1ps
`default_nettype none

module gamepad_frame_receiver_debounce_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [7:0] rx_byte, [39:8] now_ms, [55:40] clear_pressed_mask,
    // [71:56] clear_released_mask
    input  wire logic [71:0]  s_axis_tdata,
    // [0] func
    input  wire logic [0:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [15:0] stable_buttons, [31:16] raw_buttons, [47:32] pressed_events,
    // [63:48] released_events, [71:64] left_x, [79:72] left_y,
    // [87:80] right_x, [95:88] right_y, [96] link_up, [97] frame_done,
    // [98] pressed_hit, [99] released_hit, [103:100] zero
    output logic [103:0]      m_axis_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [15:0]  cfg_data
);

    logic             in_valid_reg;
    logic [71:0]      in_data_reg;
    logic             in_func_reg;
    logic             out_valid_reg;
    logic [103:0]     out_data_reg;
    logic [15:0]      debounce_reg;
    logic             advance;
    logic             step;
    gfrd_pkg::frame_t frame;
    gfrd_pkg::btn_t   btn;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= gfrd_pkg::DEBOUNCE_RESET;
        end
        else if (cfg_valid)
        begin
            debounce_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg <= s_axis_tdata;
            in_func_reg <= s_axis_tuser[0];
        end
    end

    gfrd_framer u_framer (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step && (in_func_reg == gfrd_pkg::FUNC_BYTE)),
        .rx_byte (in_data_reg[7:0]),
        .frame   (frame)
    );

    gfrd_debounce u_debounce (
        .clk                 (clk),
        .rst_n               (rst_n),
        .step                (step),
        .func                (in_func_reg),
        .now_ms              (in_data_reg[39:8]),
        .clear_pressed_mask  (in_data_reg[55:40]),
        .clear_released_mask (in_data_reg[71:56]),
        .debounce_ms         (debounce_reg),
        .frame               (frame),
        .btn                 (btn)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= {4'd0, btn.released_hit, btn.pressed_hit, frame.done,
                             frame.link_up, frame.right_y, frame.right_x,
                             frame.left_y, frame.left_x, btn.released, btn.pressed,
                             btn.raw, btn.stable};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // a completed frame can only come from outside ignore mode
    a_done_link: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[97] |-> m_axis_tdata[96])
        else $error("frame_done reported while link is down");

    // frame completion and clear hits come from different request kinds
    a_done_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[97] |-> !m_axis_tdata[98] && !m_axis_tdata[99])
        else $error("frame_done and clear hit in one result");

    // input side only backs up when the result register is full and stalled
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output stall");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tb_gamepad_frame_receiver_debounce_core.sv
// Self-checking testbench for gamepad_frame_receiver_debounce_core: framing, debounce,
// sticky events and event clears, checked against an in-bench predictor.
// Depends on gfrd_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_gamepad_frame_receiver_debounce_core;
    import gfrd_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 155;

    // input item, packed so that a literal reads func, masks, time, byte
    typedef struct packed {
        logic        func;
        logic [15:0] rel_mask;
        logic [15:0] press_mask;
        logic [31:0] now_ms;
        logic [7:0]  rx_byte;
    } gp_item_t;

    // laid out exactly as m_axis_tdata, lowest field last
    typedef struct packed {
        logic [3:0]  pad;
        logic        released_hit;
        logic        pressed_hit;
        logic        frame_done;
        logic        link_up;
        logic [7:0]  right_y;
        logic [7:0]  right_x;
        logic [7:0]  left_y;
        logic [7:0]  left_x;
        logic [15:0] released;
        logic [15:0] pressed;
        logic [15:0] raw;
        logic [15:0] stable;
    } gp_result_t;

    typedef struct packed {
        gp_item_t   item;
        logic       typed;
        gp_result_t want;
    } gp_row_t;

    localparam gp_result_t IDLE_OUT = '{4'h0, 1'b0, 1'b0, 1'b0, 1'b1,
        STICK_Y_RESET, STICK_X_RESET, STICK_Y_RESET, STICK_X_RESET,
        16'h0000, 16'h0000, 16'h0000, 16'h0000};
    localparam gp_result_t NO_WANT = '0;

    // func, released mask, pressed mask, now_ms, byte; typed rows carry their result
    localparam gp_row_t DIRECTED [24] = '{
        '{'{FUNC_BYTE,  16'h0000, 16'h0000, 32'h0000_0000, 8'h00}, 1'b1, IDLE_OUT},
        '{'{FUNC_CLEAR, 16'hFFFF, 16'hFFFF, 32'h0000_0000, 8'h00}, 1'b1, IDLE_OUT},
        '{'{FUNC_BYTE,  16'h0000, 16'h0000, 32'h0000_0014, START_BYTE}, 1'b1, IDLE_OUT},
        '{'{FUNC_BYTE,  16'h0000, 16'h0000, 32'h0000_0014, 8'hFF}, 1'b0, NO_WANT},
        '{'{FUNC_BYTE,  16'h0000, 16'h0000, 32'h0000_0014, 8'hFF}, 1'b0, NO_WANT},
        '{'{FUNC_BYTE,  16'h0000, 16'h0000, 32'h0000_0014, 8'h00}, 1'b0, NO_WANT},
        '{'{FUNC_BYTE,  16'h0000, 16'h0000, 32'h0000_0014, 8'hFF}, 1'b0, NO_WANT},
        '{'{FUNC_BYTE,  16'h0000, 16'h0000, 32'h0000_0014, 8'h00}, 1'b0, NO_WANT},
        '{'{FUNC_BYTE,  16'h0000, 16'h0000, 32'h0000_0014, 8'hFF}, 1'b0, NO_WANT},
        '{'{FUNC_BYTE,  16'h0000, 16'h0000, 32'h0000_0014, END_BYTE}, 1'b0, NO_WANT},
        // same buttons exactly 30 ms later, short frame: end byte lands in a stick slot, the rest stay stale
        '{'{FUNC_BYTE,  16'h0000, 16'h0000, 32'h0000_0032, START_BYTE}, 1'b0, NO_WANT},
        '{'{FUNC_BYTE,  16'h0000, 16'h0000, 32'h0000_0032, 8'hFF}, 1'b0, NO_WANT},
        '{'{FUNC_BYTE,  16'h0000, 16'h0000, 32'h0000_0032, 8'hFF}, 1'b0, NO_WANT},
        '{'{FUNC_BYTE,  16'h0000, 16'h0000, 32'h0000_0032, END_BYTE}, 1'b0, NO_WANT},
        // disconnect, end byte ignored, start leaves ignore, start inside frame is data
        '{'{FUNC_BYTE,  16'h0000, 16'h0000, 32'h0000_003C, DISCONNECT_BYTE}, 1'b0, NO_WANT},
        '{'{FUNC_BYTE,  16'h0000, 16'h0000, 32'h0000_003C, END_BYTE}, 1'b0, NO_WANT},
        '{'{FUNC_BYTE,  16'h0000, 16'h0000, 32'h0000_003C, START_BYTE}, 1'b0, NO_WANT},
        '{'{FUNC_BYTE,  16'h0000, 16'h0000, 32'h0000_003C, START_BYTE}, 1'b0, NO_WANT},
        '{'{FUNC_BYTE,  16'h0000, 16'h0000, 32'h0000_003D, 8'h00}, 1'b0, NO_WANT},
        '{'{FUNC_BYTE,  16'h0000, 16'h0000, 32'hFFFF_FFFF, END_BYTE}, 1'b0, NO_WANT},
        '{'{FUNC_CLEAR, 16'h0000, 16'h8000, 32'hFFFF_FFFF, 8'h00}, 1'b0, NO_WANT},
        '{'{FUNC_CLEAR, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 8'h00}, 1'b0, NO_WANT},
        '{'{FUNC_BYTE,  16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF}, 1'b0, NO_WANT},
        '{'{FUNC_CLEAR, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF}, 1'b0, NO_WANT}
    };

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [71:0]  s_axis_tdata = '0;
    logic [0:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [15:0]  cfg_data = '0;

    gamepad_frame_receiver_debounce_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic [7:0]       gp_store [FRAME_DEPTH];
    logic [IDX_W-1:0] gp_widx = '0;
    logic             gp_in_frame = 1'b0;
    logic             gp_ignoring = 1'b0;
    logic [15:0]      gp_raw = '0;
    logic [15:0]      gp_stable = '0;
    logic [15:0]      gp_pressed = '0;
    logic [15:0]      gp_released = '0;
    logic [31:0]      gp_db_start = '0;
    logic [15:0]      gp_db_ms = DEBOUNCE_RESET;
    logic [7:0]       gp_lx = STICK_X_RESET;
    logic [7:0]       gp_ly = STICK_Y_RESET;
    logic [7:0]       gp_rx = STICK_X_RESET;
    logic [7:0]       gp_ry = STICK_Y_RESET;

    gp_result_t expected_reports [$];
    int         fail_count = 0;
    int         cycle_count = 0;
    bit         tx_idle = 1'b1;
    bit         rx_idle = 1'b1;
    int         rx_hold_req = 0;
    logic [31:0] gp_now = '0;
    logic [15:0] btn_held = '0;
    gp_result_t mon_got;
    gp_result_t mon_want;

    function automatic gp_result_t gamepad_step(input gp_item_t it);
        gp_result_t r;
        logic [15:0] frame_btn;
        logic [15:0] prev;
        logic [15:0] hp;
        logic [15:0] hr;
        logic [31:0] elapsed;
        r = '0;
        if (it.func == FUNC_BYTE)
        begin
            if (it.rx_byte == DISCONNECT_BYTE)
            begin
                gp_in_frame = 1'b0;
                gp_widx = '0;
                gp_ignoring = 1'b1;
            end
            else if (gp_ignoring)
            begin
                if (it.rx_byte == START_BYTE)
                begin
                    gp_ignoring = 1'b0;
                    gp_in_frame = 1'b1;
                    gp_widx = '0;
                end
            end
            else if (gp_in_frame)
            begin
                // the end byte itself lands at the current slot too
                gp_store[gp_widx] = it.rx_byte;
                if (it.rx_byte != END_BYTE)
                begin
                    if (gp_widx != LAST_IDX)
                        gp_widx = gp_widx + 1'b1;
                end
                else
                begin
                    gp_in_frame = 1'b0;
                    gp_widx = '0;
                    r.frame_done = 1'b1;
                    frame_btn = {gp_store[0], gp_store[1]};
                    gp_ly = gp_store[2];
                    gp_lx = gp_store[3];
                    gp_ry = gp_store[4];
                    gp_rx = gp_store[5];
                    elapsed = it.now_ms - gp_db_start;
                    if (frame_btn != gp_raw)
                    begin
                        gp_raw = frame_btn;
                        gp_db_start = it.now_ms;
                    end
                    else if (!elapsed[31] && elapsed >= {16'h0000, gp_db_ms}
                             && gp_stable != frame_btn)
                    begin
                        prev = gp_stable;
                        gp_stable = frame_btn;
                        gp_pressed = gp_pressed | (frame_btn & ~prev);
                        gp_released = gp_released | (prev & ~frame_btn);
                    end
                end
            end
            else if (it.rx_byte == START_BYTE)
            begin
                gp_in_frame = 1'b1;
                gp_widx = '0;
            end
        end
        else
        begin
            hp = gp_pressed & it.press_mask;
            hr = gp_released & it.rel_mask;
            gp_pressed = gp_pressed & ~hp;
            gp_released = gp_released & ~hr;
            r.pressed_hit = |hp;
            r.released_hit = |hr;
        end
        r.stable = gp_stable;
        r.raw = gp_raw;
        r.pressed = gp_pressed;
        r.released = gp_released;
        r.left_x = gp_lx;
        r.left_y = gp_ly;
        r.right_x = gp_rx;
        r.right_y = gp_ry;
        r.link_up = !gp_ignoring;
        return r;
    endfunction

    // offer one item; the expectation is queued at the transfer edge
    task automatic send_item(input gp_item_t it, input bit typed = 1'b0,
                             input gp_result_t want = '0);
        int gap;
        gp_result_t predicted;
        gap = tx_idle ? $urandom_range(0, 17) : 0;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {it.rel_mask, it.press_mask, it.now_ms, it.rx_byte};
        s_axis_tuser <= it.func;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = gamepad_step(it);
        expected_reports.push_back(typed ? want : predicted);
    endtask

    task automatic send_byte(input logic [7:0] b);
        gp_item_t it;
        it.func = FUNC_BYTE;
        it.rx_byte = b;
        it.now_ms = gp_now;
        it.press_mask = 16'($urandom);
        it.rel_mask = 16'($urandom);
        gp_now += $urandom_range(0, 2);
        send_item(it);
    endtask

    task automatic send_clear(input logic [15:0] pmask, input logic [15:0] rmask);
        gp_item_t it;
        it.func = FUNC_CLEAR;
        it.rx_byte = 8'($urandom);
        it.now_ms = gp_now;
        it.press_mask = pmask;
        it.rel_mask = rmask;
        send_item(it);
    endtask

    // clean frames keep end and disconnect bytes out of the payload
    task automatic send_frame(input logic [15:0] btn, input int len, input bit clean);
        logic [7:0] b;
        send_byte(START_BYTE);
        for (int i = 0; i < len; i++)
        begin
            b = (i == 0) ? btn[15:8] : (i == 1) ? btn[7:0] : 8'($urandom);
            if (clean && (b == END_BYTE || b == DISCONNECT_BYTE))
                b = b ^ 8'h01;
            send_byte(b);
        end
        send_byte(END_BYTE);
    endtask

    task automatic wait_results_done();
        s_axis_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_debounce(input logic [15:0] value);
        wait_results_done();
        repeat (3) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        gp_db_ms = value;
    endtask

    task automatic random_phase(input int n);
        int counted;
        int pick;
        int len;
        int k;
        counted = 0;
        while (counted < n)
        begin
            if ($urandom_range(0, 29) == 0)
                tx_idle = !tx_idle;
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                if ($urandom_range(0, 3) == 0)
                    btn_held = ($urandom_range(0, 1) == 1)
                        ? btn_held ^ (16'h0001 << $urandom_range(0, 15)) : 16'($urandom);
                k = $urandom_range(0, 9);
                len = (k == 0) ? $urandom_range(0, 5) : (k == 1) ? $urandom_range(7, 12) : 6;
                send_frame(btn_held, len, 1'b1);
                counted += len + 2;
                gp_now += $urandom_range(0, 40);
            end
            else if (pick < 72)
            begin
                send_clear(($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom),
                           ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom));
                counted++;
            end
            else if (pick < 78)
            begin
                send_byte(DISCONNECT_BYTE);
                k = $urandom_range(0, 3);
                repeat (k) send_byte(8'($urandom));
                counted += k + 1;
            end
            else if (pick < 88)
            begin
                send_byte(8'($urandom));
                counted++;
            end
            else if (pick < 93)
            begin
                // time jumps: anywhere, backwards, around the longest debounce, near wrap
                case ($urandom_range(0, 3))
                    0: gp_now = $urandom;
                    1: gp_now -= $urandom_range(1, 200);
                    2: gp_now += $urandom_range(60000, 70000);
                    default: gp_now = 32'hFFFF_FFC0;
                endcase
            end
            else
            begin
                send_byte(START_BYTE);
                len = $urandom_range(1, 10);
                repeat (len) send_byte(8'($urandom));
                counted += len + 1;
            end
        end
    endtask

    // result side: random stalls, long hold when asked
    initial
    begin
        int stall;
        int transfers;
        transfers = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (rx_hold_req != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold_req) @(posedge clk);
                rx_hold_req = 0;
            end
            transfers++;
            if (transfers % 40 == 0)
                rx_idle = ($urandom_range(0, 3) != 0);
            stall = rx_idle ? $urandom_range(0, 17) : 0;
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            mon_got = m_axis_tdata;
            if (expected_reports.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: got %h", m_axis_tdata);
            end
            else
            begin
                mon_want = expected_reports.pop_front();
                if (mon_got.stable !== mon_want.stable || mon_got.raw !== mon_want.raw
                    || mon_got.pressed !== mon_want.pressed
                    || mon_got.released !== mon_want.released
                    || mon_got.left_x !== mon_want.left_x
                    || mon_got.left_y !== mon_want.left_y
                    || mon_got.right_x !== mon_want.right_x
                    || mon_got.right_y !== mon_want.right_y
                    || mon_got.link_up !== mon_want.link_up
                    || mon_got.frame_done !== mon_want.frame_done
                    || mon_got.pressed_hit !== mon_want.pressed_hit
                    || mon_got.released_hit !== mon_want.released_hit
                    || mon_got.pad !== mon_want.pad)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch at %0t: expected %h got %h", $realtime,
                                 mon_want, mon_got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_gamepad_frame_receiver_debounce_core: done, errors");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < FRAME_DEPTH; i++)
            gp_store[i] = 8'h00;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < $size(DIRECTED); i++)
            send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].want);
        wait_results_done();

        gp_now = 32'h0000_0100;
        random_phase(PHASE_ITEMS);

        // fill the core while results are held back, then let it all drain
        rx_hold_req = 150;
        tx_idle = 1'b0;
        repeat (3) send_frame(btn_held, 6, 1'b1);
        tx_idle = 1'b1;
        wait_results_done();

        write_debounce(16'h0000);
        random_phase(PHASE_ITEMS);
        write_debounce(16'hFFFF);
        random_phase(PHASE_ITEMS);
        write_debounce(16'($urandom_range(1, 200)));
        random_phase(PHASE_ITEMS);
        write_debounce(16'd1);
        random_phase(PHASE_ITEMS / 2);
        write_debounce(DEBOUNCE_RESET);
        random_phase(PHASE_ITEMS / 2);

        wait_results_done();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && expected_reports.size() == 0)
            $display("tb_gamepad_frame_receiver_debounce_core: done, clean");
        else
            $display("tb_gamepad_frame_receiver_debounce_core: done, errors");
        $finish;
    end

endmodule
